// ----- design/avd_pkg.sv -----
// ----------------------------------------------------------------------------
// avd_pkg: shared types and constants of the VAG ADPCM decoder
// Holds the sequencer states, the control group of the shared multiply unit,
// the fixed history widths and the predictor coefficient tables.
// ----------------------------------------------------------------------------
package avd_pkg;

	// History words are signed 40-bit fixed-point values.
	localparam int HIST_W = 40;
	// Predictor coefficients are signed values in units of 1/64.
	localparam int COEF_W = 8;
	// Product of one history word and one coefficient.
	localparam int PROD_W = HIST_W + COEF_W;
	// Sum of two products.
	localparam int SUM_W = PROD_W + 1;
	// Predictor coefficient scale is 2^PRED_SHIFT.
	localparam int PRED_SHIFT = 6;

	localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

	// Flag byte that ends decoding of a stream.
	localparam logic [7:0] FLAG_END = 8'd7;
	// Highest filter code that selects a real predictor.
	localparam logic [3:0] FILTER_MAX = 4'd4;
	// Last byte position of a 16-byte frame.
	localparam logic [3:0] POS_LAST = 4'd15;
	localparam logic [3:0] POS_HEAD = 4'd0;
	localparam logic [3:0] POS_FLAG = 4'd1;
	localparam logic [3:0] POS_DATA = 4'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_FINISH,
		ST_EMIT
	} state_t;

	// Control group of the shared multiply-accumulate unit.
	typedef struct packed {
		logic mul_en;    // capture operand times coefficient
		logic acc_load;  // move the previous product into the accumulator
	} mac_ctl_t;

	// First-tap coefficient of each filter.
	function automatic logic signed [COEF_W-1:0] coef_one(input logic [2:0] filt);
		logic signed [COEF_W-1:0] c;
		case (filt)
			3'd1: c = 8'sd60;
			3'd2: c = 8'sd115;
			3'd3: c = 8'sd98;
			3'd4: c = 8'sd122;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// Second-tap coefficient of each filter.
	function automatic logic signed [COEF_W-1:0] coef_two(input logic [2:0] filt);
		logic signed [COEF_W-1:0] c;
		case (filt)
			3'd2: c = -8'sd52;
			3'd3: c = -8'sd55;
			3'd4: c = -8'sd60;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage

// ----- design/avd_mac.sv -----
// ----------------------------------------------------------------------------
// avd_mac: shared multiply-accumulate unit of the predictor
// One signed 40x8 multiplier with a product register and an accumulator.
// Two passes give the sum of both predictor taps.
// ----------------------------------------------------------------------------
module avd_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  avd_pkg::mac_ctl_t                      ctl,
	input  logic signed [avd_pkg::HIST_W-1:0]      op_a,
	input  logic signed [avd_pkg::COEF_W-1:0]      coef,
	output logic signed [avd_pkg::SUM_W-1:0]       sum
);

	logic signed [avd_pkg::PROD_W-1:0] prod_d;
	logic signed [avd_pkg::PROD_W-1:0] prod_q;
	logic signed [avd_pkg::PROD_W-1:0] acc_q;
	logic                              prod_ok_q;

	// One multiplication per cycle, registered before any further use.
	assign prod_d = op_a * coef;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.acc_load) begin
			acc_q <= prod_q;
		end
	end

	// Tracks that the product register holds a fresh value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_ok_q <= 1'b0;
		end else begin
			prod_ok_q <= ctl.mul_en;
		end
	end

	// Sum of both taps, read in the cycle after the second product.
	assign sum = avd_pkg::SUM_W'(acc_q) + avd_pkg::SUM_W'(prod_q);

	// An accumulator load always takes a product made in the cycle before.
	a_load_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_load |-> prod_ok_q)
		else $error("accumulator loaded from a stale product");

	// Every load of the accumulator comes with the second product.
	a_load_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.acc_load |-> ctl.mul_en)
		else $error("accumulator load without second product");

	// The first product is always followed by the second one.
	a_pass_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.mul_en && !ctl.acc_load) |=> (ctl.mul_en && ctl.acc_load))
		else $error("predictor pass broken after first product");

endmodule

// ----- design/adpcm_vag_decoder.sv -----
// ----------------------------------------------------------------------------
// adpcm_vag_decoder: VAG ADPCM stream decoder, one byte per request
// Skips the stream header, parses frame shift/filter and flag bytes, and
// decodes each data byte into two 16-bit PCM samples with a two-tap predictor.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -------------------------------------------
//  input    in_valid / in_ready    stream_byte[7:0], stream_start
//  output   out_valid / out_ready  first_sample[15:0], second_sample[15:0],
//                                  end_marker
//
//  Header and shift/filter bytes, and flag bytes other than 7, give no result.
//  A data byte passes through the accept step, then for each nibble two
//  passes of the shared multiplier and one finish step for prediction,
//  rounding and saturation, then the output register load, before in_ready
//  returns. A flag byte of 7 goes from the accept step to the output load.
//  arst_n clears the sequencer, the stream position and the history.
//  A stalled output holds the sequencer in its emit state until the output
//  register is free; the input side stays closed while the result waits there.
// ----------------------------------------------------------------------------
module adpcm_vag_decoder #(
	parameter int HEADER_BYTES  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         stream_byte,
	input  logic               stream_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] first_sample,
	output logic signed [15:0] second_sample,
	output logic               end_marker
);

	localparam int HCW = $clog2(HEADER_BYTES + 2);
	localparam logic [HCW-1:0] HB_C = HCW'(HEADER_BYTES);
	localparam int HW = avd_pkg::HIST_W;
	localparam int XW = avd_pkg::SUM_W + 1;
	localparam int YW = HW + 1;
	localparam logic signed [YW-1:0] HALF = YW'(1) << (FRACTION_BITS - 1);
	localparam logic signed [YW-1:0] OUT_MAX = YW'(32767);
	localparam logic signed [YW-1:0] OUT_MIN = -YW'(32768);

	avd_pkg::state_t state_q, state_d;

	// Stream position state.
	logic           in_header_q;
	logic [HCW-1:0] hcnt_q;
	logic [3:0]     pos_q;
	logic [3:0]     shift_q;
	logic [2:0]     filt_q;
	logic           stopped_q;
	logic signed [HW-1:0] h1_q;
	logic signed [HW-1:0] h2_q;

	// Working data of the byte being decoded.
	logic [7:0]         byte_q;
	logic               nib_sel_q;
	logic signed [15:0] res_first_q;
	logic signed [15:0] res_second_q;
	logic               res_end_q;

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] out_first_q;
	logic signed [15:0] out_second_q;
	logic               out_end_q;

	logic               in_fire;
	logic               out_free;
	logic               stop_eff;
	logic               hdr_eff;
	logic [HCW-1:0]     hcnt_eff;
	logic [HCW-1:0]     hcnt_inc;
	logic [3:0]         pos_eff;
	logic               hdr_take;
	logic               live;
	logic               data_go;
	logic               end_go;
	logic [2:0]         filt_new;

	avd_pkg::mac_ctl_t                  mac_ctl;
	logic signed [HW-1:0]               mac_op;
	logic signed [avd_pkg::COEF_W-1:0]  mac_coef;
	logic signed [avd_pkg::SUM_W-1:0]   mac_sum;

	logic [3:0]           nib;
	logic signed [15:0]   nib_word;
	logic signed [15:0]   base_sh;
	logic signed [XW-1:0] x_full;
	logic signed [HW-1:0] h_new;
	logic signed [YW-1:0] y_val;
	logic signed [YW-1:0] q_val;
	logic signed [YW-1:0] r_val;
	logic signed [15:0]   sample;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Byte classification, with a stream start applied first.
	always_comb begin
		stop_eff = stream_start ? 1'b0 : stopped_q;
		hdr_eff  = stream_start ? 1'b1 : in_header_q;
		hcnt_eff = stream_start ? '0 : hcnt_q;
		pos_eff  = stream_start ? avd_pkg::POS_HEAD : pos_q;
		hcnt_inc = hcnt_eff + 1'b1;
		hdr_take = !stop_eff && hdr_eff && (hcnt_eff < HB_C);
		live     = !stop_eff && !hdr_take;
		data_go  = live && (pos_eff >= avd_pkg::POS_DATA);
		end_go   = live && (pos_eff == avd_pkg::POS_FLAG) &&
			(stream_byte == avd_pkg::FLAG_END);
		filt_new = (stream_byte[7:4] > avd_pkg::FILTER_MAX) ? 3'd0 : stream_byte[6:4];
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			avd_pkg::ST_IDLE: begin
				if (in_fire && data_go) begin
					state_d = avd_pkg::ST_MUL_A;
				end else if (in_fire && end_go) begin
					state_d = avd_pkg::ST_EMIT;
				end
			end
			avd_pkg::ST_MUL_A: state_d = avd_pkg::ST_MUL_B;
			avd_pkg::ST_MUL_B: state_d = avd_pkg::ST_FINISH;
			avd_pkg::ST_FINISH: begin
				state_d = nib_sel_q ? avd_pkg::ST_EMIT : avd_pkg::ST_MUL_A;
			end
			avd_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = avd_pkg::ST_IDLE;
				end
			end
			default: state_d = avd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operands.
	always_comb begin
		in_ready         = 1'b0;
		mac_ctl.mul_en   = 1'b0;
		mac_ctl.acc_load = 1'b0;
		mac_op           = h1_q;
		mac_coef         = avd_pkg::coef_one(filt_q);
		case (state_q)
			avd_pkg::ST_IDLE: in_ready = 1'b1;
			avd_pkg::ST_MUL_A: mac_ctl.mul_en = 1'b1;
			avd_pkg::ST_MUL_B: begin
				mac_ctl.mul_en   = 1'b1;
				mac_ctl.acc_load = 1'b1;
				mac_op           = h2_q;
				mac_coef         = avd_pkg::coef_two(filt_q);
			end
			default: begin
			end
		endcase
	end

	avd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mac_op),
		.coef   (mac_coef),
		.sum    (mac_sum)
	);

	// Finish step: shifted nibble plus prediction, then round and saturate.
	always_comb begin
		nib      = nib_sel_q ? byte_q[7:4] : byte_q[3:0];
		nib_word = {nib, 12'h000};
		base_sh  = nib_word >>> shift_q;
		x_full   = (XW'(base_sh) <<< FRACTION_BITS) +
			XW'(mac_sum >>> avd_pkg::PRED_SHIFT);
		if (x_full > XW'(avd_pkg::HIST_MAX)) begin
			h_new = avd_pkg::HIST_MAX;
		end else if (x_full < XW'(avd_pkg::HIST_MIN)) begin
			h_new = avd_pkg::HIST_MIN;
		end else begin
			h_new = x_full[HW-1:0];
		end
		y_val = YW'(h_new) + HALF;
		q_val = y_val >>> FRACTION_BITS;
		// Floor plus one on a negative value with a fraction truncates toward zero.
		if (y_val[YW-1] && (|y_val[FRACTION_BITS-1:0])) begin
			r_val = q_val + YW'(1);
		end else begin
			r_val = q_val;
		end
		if (r_val > OUT_MAX) begin
			sample = 16'sh7fff;
		end else if (r_val < OUT_MIN) begin
			sample = -16'sh8000;
		end else begin
			sample = r_val[15:0];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= avd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stream position, frame parameters and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
			hcnt_q      <= '0;
			pos_q       <= avd_pkg::POS_HEAD;
			shift_q     <= '0;
			filt_q      <= '0;
			stopped_q   <= 1'b0;
			h1_q        <= '0;
			h2_q        <= '0;
			nib_sel_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				stopped_q <= stop_eff || end_go;
				nib_sel_q <= 1'b0;
				if (stop_eff) begin
					in_header_q <= hdr_eff;
				end else if (hdr_take) begin
					in_header_q <= (hcnt_inc < HB_C);
				end else begin
					in_header_q <= 1'b0;
				end
				hcnt_q <= hdr_take ? hcnt_inc : hcnt_eff;
				if (stream_start) begin
					h1_q <= '0;
					h2_q <= '0;
				end
				if (live && (pos_eff == avd_pkg::POS_HEAD)) begin
					shift_q <= stream_byte[3:0];
					filt_q  <= filt_new;
				end else if (stream_start) begin
					shift_q <= '0;
					filt_q  <= '0;
				end
				if (!live) begin
					pos_q <= pos_eff;
				end else if (pos_eff == avd_pkg::POS_HEAD) begin
					pos_q <= avd_pkg::POS_FLAG;
				end else if (pos_eff == avd_pkg::POS_FLAG) begin
					pos_q <= end_go ? avd_pkg::POS_HEAD : avd_pkg::POS_DATA;
				end else if (pos_eff == avd_pkg::POS_LAST) begin
					pos_q <= avd_pkg::POS_HEAD;
				end else begin
					pos_q <= pos_eff + 4'd1;
				end
			end else if (state_q == avd_pkg::ST_FINISH) begin
				h2_q      <= h1_q;
				h1_q      <= h_new;
				nib_sel_q <= !nib_sel_q;
			end
		end
	end

	// Result staging while the byte is decoded.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_q       <= stream_byte;
			res_first_q  <= '0;
			res_second_q <= '0;
			res_end_q    <= end_go;
		end else if (state_q == avd_pkg::ST_FINISH) begin
			if (nib_sel_q) begin
				res_second_q <= sample;
			end else begin
				res_first_q <= sample;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == avd_pkg::ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if ((state_q == avd_pkg::ST_EMIT) && out_free) begin
			out_first_q  <= res_first_q;
			out_second_q <= res_second_q;
			out_end_q    <= res_end_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign first_sample  = out_first_q;
	assign second_sample = out_second_q;
	assign end_marker    = out_end_q;

	// An end-of-stream result carries silent samples.
	a_end_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_marker) |-> (first_sample == 16'sd0 && second_sample == 16'sd0))
		else $error("end marker result with nonzero samples");

	// A byte taken while stopped and without a start starts no decoding.
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && stopped_q && !stream_start) |=> (state_q == avd_pkg::ST_IDLE))
		else $error("decoding started on a stopped stream");

	// The header count never passes the header length.
	a_hcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q <= HB_C)
		else $error("header count beyond header length");

	// While the header is skipped, no frame has begun.
	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_header_q |-> (pos_q == avd_pkg::POS_HEAD))
		else $error("frame position moved inside header");

	// The second nibble's finish step always hands the byte to the output.
	a_finish_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == avd_pkg::ST_FINISH && nib_sel_q) |=> (state_q == avd_pkg::ST_EMIT))
		else $error("second nibble finished without emit");

endmodule
